// ===== rtl/core/pulse_derivative_smoothing_filter_core_macros.svh =====
// Assertion macros used by the checker of the pulse filter core.
// No dependencies; take it in by `include before the first assertion.
`ifndef PULSE_DERIVATIVE_SMOOTHING_FILTER_CORE_MACROS_SVH
`define PULSE_DERIVATIVE_SMOOTHING_FILTER_CORE_MACROS_SVH

// Overlapping check: consequent in the same cycle as the antecedent.
`define PDSF_ASSERT_SAME(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("pdsf: property failed");

// Next-cycle check: consequent in the cycle after the antecedent.
`define PDSF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("pdsf: property failed");

`endif

// ===== rtl/core/pdsf_pkg.sv =====
// Shared types and constants of the pulse derivative / smoothing filter.
// No dependencies; the datapath, controller and top level refer to it by scoped names.
package pdsf_pkg;

  // Field widths
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned D_W        = 5;
  localparam int unsigned WIN_W      = 6;

  // Span limits
  localparam int unsigned MAX_HALF_SPAN    = 31;
  localparam int unsigned MAX_WINDOW       = 63;
  localparam int unsigned LOOK_LIMIT       = 31;
  localparam int unsigned WIN_LIMIT        = 63;
  localparam int unsigned MAX_PULSE_LENGTH = 65535;
  localparam int unsigned D_LIM =
    (MAX_HALF_SPAN < LOOK_LIMIT) ? MAX_HALF_SPAN : LOOK_LIMIT;
  localparam int unsigned W_LIM = (MAX_WINDOW < WIN_LIMIT) ? MAX_WINDOW : WIN_LIMIT;

  // Sample history ring
  localparam int unsigned HIST_DEPTH = 64;
  localparam int unsigned HIST_AW    = $clog2(HIST_DEPTH);

  // Datapath widths
  localparam int unsigned ACC_W  = 22;  // boxcar sum
  localparam int unsigned PROD_W = 33;  // difference times gain
  localparam int unsigned BD_W   = 22;  // baseline times d
  localparam int unsigned NUM_W  = 34;  // derivative numerator
  localparam int unsigned DIVD_W = 23;  // divider dividend magnitude
  localparam int unsigned DIVS_W = 6;   // divider divisor
  localparam int unsigned PEND_W = 6;   // outputs released at end of pulse

  // Reset values of the registers
  localparam logic [SAMPLE_W-1:0] GAIN_RESET = 16'sd256;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE      = 3'd0,
    REG_HALF_SPAN = 3'd1,
    REG_WINDOW    = 3'd2,
    REG_GAIN      = 3'd3,
    REG_BASELINE  = 3'd4
  } cfg_reg_e;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_DRAIN,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_EMIT_Q,
    ST_EMIT_B,
    ST_PEND
  } state_e;

  // Output value source
  typedef enum logic {
    OUT_QUOT,
    OUT_BASE
  } out_sel_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic     capture;
    logic     write;
    logic     rd_issue;
    logic     mul;
    logic     div_start;
    logic     out_load;
    out_sel_e out_sel;
    logic     out_end;
    logic     pend_dec;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic emit;
    logic compute;
    logic mode;
    logic last;
    logic last_rd;
    logic div_busy;
    logic out_free;
    logic pend_nz;
    logic pend_one;
  } stat_t;

endpackage

// ===== rtl/core/pdsf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pdsf_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/pdsf_div.sv =====
// Restoring serial divider, one quotient bit per cycle, unsigned operands.
// No dependencies.
module pdsf_div #(
  parameter int unsigned DvdW = 23,
  parameter int unsigned DvsW = 6
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DvdW-1:0] dividend_i,
  input  logic [DvsW-1:0] divisor_i,
  output logic            busy_o,
  output logic [DvdW-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(DvdW + 1);

  logic            busy_q;
  logic [CntW-1:0] cnt_q;
  logic [DvsW-1:0] rem_q;
  logic [DvsW-1:0] dvs_q;
  logic [DvdW-1:0] quo_q;

  logic [DvsW:0]   trial;
  logic            fits;
  logic [DvsW:0]   diff;

  // Shift in the next dividend bit and try the subtraction
  always_comb begin
    trial = {rem_q, quo_q[DvdW-1]};
    fits  = (trial >= {1'b0, dvs_q});
    diff  = trial - {1'b0, dvs_q};
  end

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(DvdW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Remainder and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvs_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DvsW-1:0] : trial[DvsW-1:0];
      quo_q <= {quo_q[DvdW-2:0], fits};
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

// ===== rtl/core/pdsf_datapath.sv =====
// Datapath: registers, sample history ring, arithmetic, divider and output stage.
// Depends on pdsf_pkg, pdsf_ram and pdsf_div.
module pdsf_datapath #(
  parameter int unsigned MaxPulseLength = pdsf_pkg::MAX_PULSE_LENGTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic [pdsf_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pdsf_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic [pdsf_pkg::SAMPLE_W-1:0]      s_data_i,
  input  logic                               s_last_i,
  input  logic                               m_ready_i,
  output logic                               m_valid_o,
  output logic [pdsf_pkg::SAMPLE_W-1:0]      m_data_o,
  output logic                               m_last_o,
  input  pdsf_pkg::cmd_t                     cmd_i,
  output pdsf_pkg::stat_t                    stat_o
);

  localparam int unsigned IdxW = $clog2(MaxPulseLength + 1);
  localparam int unsigned CmpW = (IdxW > 7) ? IdxW : 7;
  localparam int unsigned SW   = pdsf_pkg::SAMPLE_W;
  localparam int unsigned DW   = pdsf_pkg::D_W;
  localparam int unsigned WW   = pdsf_pkg::WIN_W;
  localparam int unsigned AW   = pdsf_pkg::HIST_AW;
  localparam int unsigned PW   = pdsf_pkg::PEND_W;

  // Register file
  logic                 cfg_mode_q;
  logic [DW-1:0]        cfg_hs_q;
  logic [WW-1:0]        cfg_win_q;
  logic [SW-1:0]        cfg_gain_q;
  logic [SW-1:0]        cfg_base_q;

  // Per-pulse copies
  logic                 lat_mode_q;
  logic [DW-1:0]        lat_d_q;
  logic [WW-1:0]        lat_w_q;
  logic signed [SW-1:0] lat_gain_q;
  logic signed [SW-1:0] lat_base_q;

  logic [DW-1:0]        d_eff;
  logic [WW-1:0]        w_eff;

  // Item and sequencing state
  logic [SW-1:0]        sample_q;
  logic                 last_q;
  logic [IdxW-1:0]      idx_q;
  logic [AW-1:0]        wptr_q;
  logic [AW-1:0]        cur_ptr_q;
  logic [AW-1:0]        age_q;
  logic [WW-1:0]        rd_left_q;
  logic                 rd_vld_q;
  logic [PW-1:0]        pend_q;

  // Arithmetic
  logic signed [pdsf_pkg::ACC_W-1:0]  acc_q;
  logic signed [pdsf_pkg::PROD_W-1:0] prod_q;
  logic signed [pdsf_pkg::BD_W-1:0]   bd_q;
  logic                               neg_q;
  logic signed [SW:0]                 diff;
  logic signed [DW:0]                 d_signed;
  logic signed [pdsf_pkg::NUM_W-1:0]  num;
  logic [pdsf_pkg::NUM_W-1:0]         num_abs;
  logic [pdsf_pkg::ACC_W-1:0]         acc_abs;
  logic [pdsf_pkg::DIVD_W-1:0]        dvd;
  logic [pdsf_pkg::DIVS_W-1:0]        dvs;
  logic                               neg_d;
  logic                               div_busy;
  logic [pdsf_pkg::DIVD_W-1:0]        quo;

  // Lookahead and decisions
  logic [DW-1:0]        look;
  logic [CmpW-1:0]      j_ext;
  logic [CmpW-1:0]      look_ext;
  logic [CmpW-1:0]      two_look;
  logic                 emit;
  logic                 compute;

  logic [AW-1:0]        raddr;
  logic [SW-1:0]        rdata;

  // Output stage
  logic                 m_valid_q;
  logic [SW-1:0]        m_data_q;
  logic                 m_last_q;
  logic                 out_free;
  logic [SW-1:0]        out_val;

  // Saturate a signed magnitude to 16 bits
  function automatic logic [SW-1:0] sat_mag(input logic neg,
                                            input logic [pdsf_pkg::DIVD_W-1:0] q);
    logic [SW-1:0] r;
    if (neg) begin
      if (q > pdsf_pkg::DIVD_W'(32768)) begin
        r = 16'h8000;
      end else begin
        r = (~q[SW-1:0]) + 1'b1;
      end
    end else begin
      if (q > pdsf_pkg::DIVD_W'(32767)) begin
        r = 16'h7fff;
      end else begin
        r = q[SW-1:0];
      end
    end
    return r;
  endfunction

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_mode_q <= 1'b0;
      cfg_hs_q   <= DW'(1);
      cfg_win_q  <= WW'(1);
      cfg_gain_q <= pdsf_pkg::GAIN_RESET;
      cfg_base_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pdsf_pkg::REG_MODE:      cfg_mode_q <= cfg_data_i[0];
        pdsf_pkg::REG_HALF_SPAN: cfg_hs_q   <= cfg_data_i[DW-1:0];
        pdsf_pkg::REG_WINDOW:    cfg_win_q  <= cfg_data_i[WW-1:0];
        pdsf_pkg::REG_GAIN:      cfg_gain_q <= cfg_data_i;
        pdsf_pkg::REG_BASELINE:  cfg_base_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Treat a zero span or window as one, clamp to the limits
  always_comb begin
    d_eff = (cfg_hs_q == '0) ? DW'(1) : cfg_hs_q;
    if (d_eff > DW'(pdsf_pkg::D_LIM)) begin
      d_eff = DW'(pdsf_pkg::D_LIM);
    end
    w_eff = (cfg_win_q == '0) ? WW'(1) : cfg_win_q;
    if (w_eff > WW'(pdsf_pkg::W_LIM)) begin
      w_eff = WW'(pdsf_pkg::W_LIM);
    end
  end

  // Take the settings at the first sample of a pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_mode_q <= 1'b0;
      lat_d_q    <= DW'(1);
      lat_w_q    <= WW'(1);
      lat_gain_q <= pdsf_pkg::GAIN_RESET;
      lat_base_q <= '0;
    end else if (cmd_i.capture && (idx_q == '0)) begin
      lat_mode_q <= cfg_mode_q;
      lat_d_q    <= d_eff;
      lat_w_q    <= w_eff;
      lat_gain_q <= cfg_gain_q;
      lat_base_q <= cfg_base_q;
    end
  end

  // Hold the accepted item
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sample_q <= s_data_i;
      last_q   <= s_last_i;
    end
  end

  // Decide what this sample releases
  always_comb begin
    look     = lat_mode_q ? lat_w_q[WW-1:1] : lat_d_q;
    j_ext    = CmpW'(idx_q);
    look_ext = CmpW'(look);
    two_look = CmpW'({look, 1'b0});
    emit     = (j_ext >= look_ext);
    compute  = (j_ext >= two_look);
  end

  // Advance index, ring pointer, read sequence and pending count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      wptr_q    <= '0;
      cur_ptr_q <= '0;
      age_q     <= '0;
      rd_left_q <= '0;
      rd_vld_q  <= 1'b0;
      pend_q    <= '0;
    end else begin
      rd_vld_q <= cmd_i.rd_issue;
      if (cmd_i.write) begin
        cur_ptr_q <= wptr_q;
        wptr_q    <= wptr_q + 1'b1;
        if (last_q) begin
          idx_q <= '0;
        end else if (idx_q < IdxW'(MaxPulseLength)) begin
          idx_q <= idx_q + 1'b1;
        end
        if (lat_mode_q) begin
          age_q     <= {lat_w_q[WW-1:1], 1'b0};
          rd_left_q <= lat_w_q;
        end else begin
          age_q     <= {lat_d_q, 1'b0};
          rd_left_q <= WW'(1);
        end
        if (!last_q) begin
          pend_q <= '0;
        end else if (emit) begin
          pend_q <= PW'(look);
        end else begin
          pend_q <= PW'(j_ext[DW-1:0]) + 1'b1;
        end
      end else begin
        if (cmd_i.rd_issue) begin
          age_q     <= age_q - 1'b1;
          rd_left_q <= rd_left_q - 1'b1;
        end
        if (cmd_i.pend_dec) begin
          pend_q <= pend_q - 1'b1;
        end
      end
    end
  end

  // Sample history ring
  assign raddr = cur_ptr_q - age_q;

  pdsf_ram #(
    .Width (SW),
    .Depth (pdsf_pkg::HIST_DEPTH)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (cmd_i.write),
    .waddr_i (wptr_q),
    .wdata_i (sample_q),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Accumulate returned samples; baseline times d for the derivative offset
  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      acc_q <= '0;
      bd_q  <= lat_base_q * d_signed;
    end else if (rd_vld_q) begin
      acc_q <= acc_q + pdsf_pkg::ACC_W'(signed'(rdata));
    end
  end

  assign d_signed = signed'({1'b0, lat_d_q});

  // Difference times gain
  assign diff = signed'({sample_q[SW-1], sample_q}) - signed'(acc_q[SW:0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= diff * lat_gain_q;
    end
  end

  // Divider operands: magnitude and sign
  always_comb begin
    num     = pdsf_pkg::NUM_W'(prod_q) + (pdsf_pkg::NUM_W'(bd_q) <<< 9);
    num_abs = num[pdsf_pkg::NUM_W-1] ? (~num + 1'b1) : num;
    acc_abs = acc_q[pdsf_pkg::ACC_W-1] ? (~acc_q + 1'b1) : acc_q;
    if (lat_mode_q) begin
      neg_d = acc_q[pdsf_pkg::ACC_W-1];
      dvd   = pdsf_pkg::DIVD_W'(acc_abs);
      dvs   = lat_w_q;
    end else begin
      neg_d = num[pdsf_pkg::NUM_W-1];
      dvd   = num_abs[31:9];
      dvs   = pdsf_pkg::DIVS_W'(lat_d_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      neg_q <= neg_d;
    end
  end

  pdsf_div #(
    .DvdW (pdsf_pkg::DIVD_W),
    .DvsW (pdsf_pkg::DIVS_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .busy_o     (div_busy),
    .quotient_o (quo)
  );

  // Output register
  assign out_free = !m_valid_q || m_ready_i;
  assign out_val  = (cmd_i.out_sel == pdsf_pkg::OUT_QUOT) ? sat_mag(neg_q, quo) : lat_base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      m_data_q <= out_val;
      m_last_q <= cmd_i.out_end;
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;
  assign m_last_o  = m_last_q;

  // Status to the controller
  always_comb begin
    stat_o.emit     = emit;
    stat_o.compute  = compute;
    stat_o.mode     = lat_mode_q;
    stat_o.last     = last_q;
    stat_o.last_rd  = (rd_left_q == WW'(1));
    stat_o.div_busy = div_busy;
    stat_o.out_free = out_free;
    stat_o.pend_nz  = (pend_q != '0);
    stat_o.pend_one = (pend_q == PW'(1));
  end

endmodule

// ===== rtl/core/pdsf_ctrl.sv =====
// Controller state machine: sequences capture, history reads, divide and outputs.
// Depends on pdsf_pkg.
module pdsf_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_valid_i,
  output logic            s_ready_o,
  input  pdsf_pkg::stat_t stat_i,
  output pdsf_pkg::cmd_t  cmd_o
);

  pdsf_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pdsf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pdsf_pkg::ST_IDLE: begin
        if (s_valid_i) state_d = pdsf_pkg::ST_WRITE;
      end
      pdsf_pkg::ST_WRITE: begin
        if (stat_i.compute) begin
          state_d = pdsf_pkg::ST_READ;
        end else if (stat_i.emit) begin
          state_d = pdsf_pkg::ST_EMIT_B;
        end else if (stat_i.last) begin
          state_d = pdsf_pkg::ST_PEND;
        end else begin
          state_d = pdsf_pkg::ST_IDLE;
        end
      end
      pdsf_pkg::ST_READ: begin
        if (stat_i.last_rd) state_d = pdsf_pkg::ST_DRAIN;
      end
      pdsf_pkg::ST_DRAIN: begin
        state_d = stat_i.mode ? pdsf_pkg::ST_LOAD : pdsf_pkg::ST_MUL;
      end
      pdsf_pkg::ST_MUL:  state_d = pdsf_pkg::ST_LOAD;
      pdsf_pkg::ST_LOAD: state_d = pdsf_pkg::ST_DIV;
      pdsf_pkg::ST_DIV: begin
        if (!stat_i.div_busy) state_d = pdsf_pkg::ST_EMIT_Q;
      end
      pdsf_pkg::ST_EMIT_Q, pdsf_pkg::ST_EMIT_B: begin
        if (stat_i.out_free) begin
          state_d = stat_i.pend_nz ? pdsf_pkg::ST_PEND : pdsf_pkg::ST_IDLE;
        end
      end
      pdsf_pkg::ST_PEND: begin
        if (stat_i.out_free && stat_i.pend_one) state_d = pdsf_pkg::ST_IDLE;
      end
      default: state_d = pdsf_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o           = '0;
    cmd_o.out_sel   = pdsf_pkg::OUT_BASE;
    s_ready_o       = 1'b0;
    case (state_q)
      pdsf_pkg::ST_IDLE: begin
        s_ready_o     = 1'b1;
        cmd_o.capture = s_valid_i;
      end
      pdsf_pkg::ST_WRITE: cmd_o.write     = 1'b1;
      pdsf_pkg::ST_READ:  cmd_o.rd_issue  = 1'b1;
      pdsf_pkg::ST_MUL:   cmd_o.mul       = 1'b1;
      pdsf_pkg::ST_LOAD:  cmd_o.div_start = 1'b1;
      pdsf_pkg::ST_EMIT_Q: begin
        cmd_o.out_load = stat_i.out_free;
        cmd_o.out_sel  = pdsf_pkg::OUT_QUOT;
        // Flag the end of pulse when no pending outputs follow
        cmd_o.out_end  = stat_i.last && !stat_i.pend_nz;
      end
      pdsf_pkg::ST_EMIT_B: cmd_o.out_load = stat_i.out_free;
      pdsf_pkg::ST_PEND: begin
        cmd_o.out_load = stat_i.out_free;
        cmd_o.out_end  = stat_i.pend_one;
        cmd_o.pend_dec = stat_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/pulse_derivative_smoothing_filter_core.sv =====
// Top level of the pulse derivative / smoothing filter core.
// Depends on pdsf_pkg, pdsf_ctrl and pdsf_datapath (which holds pdsf_ram, pdsf_div).
//
//   channel  direction  handshake                  payload
//   s_axis   in         s_axis_tvalid/tready       tdata[15:0] sample, tlast last
//   m_axis   out        m_axis_tvalid/tready       tdata[15:0] value, tlast end_of_pulse
//   cfg      in         cfg_valid_i/cfg_ready_o    cfg_index_i register, cfg_data_i value
//
// One sample at a time. A sample that releases only a baseline output passes
// through capture, the history write and the output load; a derivative output
// adds one history read, one multiply and 23 divider steps plus one to see the
// divider done; a smoothing output reads W history samples and divides, the
// pace set by the single read port of the history RAM and the serial divider.
// At pulse end pending baseline outputs follow one per cycle unless stalled.
// Reset is asynchronous, active low, and needs no clearing pass. A stalled
// output holds in its register while the next sample is already taken.
module pulse_derivative_smoothing_filter_core #(
  parameter int unsigned MaxPulseLength = pdsf_pkg::MAX_PULSE_LENGTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Sample stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [15:0]                     s_axis_tdata,   // [15:0] sample
  input  logic                            s_axis_tlast,
  // Result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [15:0]                     m_axis_tdata,   // [15:0] value
  output logic                            m_axis_tlast,
  // Register writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pdsf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pdsf_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  pdsf_pkg::cmd_t  cmd;
  pdsf_pkg::stat_t stat;

  // Registers are always writable
  assign cfg_ready_o = 1'b1;

  pdsf_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  pdsf_datapath #(
    .MaxPulseLength (MaxPulseLength)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .s_data_i    (s_axis_tdata),
    .s_last_i    (s_axis_tlast),
    .m_ready_i   (m_axis_tready),
    .m_valid_o   (m_axis_tvalid),
    .m_data_o    (m_axis_tdata),
    .m_last_o    (m_axis_tlast),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

// ===== rtl/core/pdsf_checker.sv =====
// Port-level checker of the pulse filter core, bound to the top level.
// Depends on pulse_derivative_smoothing_filter_core_macros.svh.
`include "pulse_derivative_smoothing_filter_core_macros.svh"

module pdsf_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [15:0]                     m_axis_tdata,
  input logic                            m_axis_tlast,
  input logic                            cfg_valid_i,
  input logic                            cfg_ready_o
);

  // A waiting result keeps its value and flag
  `PDSF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

  // One sample at a time: after taking a sample the input closes
  `PDSF_ASSERT_NEXT(a_in_close, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // A new result is only loaded while a sample is in work
  `PDSF_ASSERT_SAME(a_out_src, clk_i, rst_ni, $rose(m_axis_tvalid), $past(!s_axis_tready))

  // Register port never stalls
  `PDSF_ASSERT_SAME(a_cfg_rdy, clk_i, rst_ni, cfg_valid_i, cfg_ready_o)

endmodule

bind pulse_derivative_smoothing_filter_core pdsf_checker u_pdsf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .cfg_valid_i   (cfg_valid_i),
  .cfg_ready_o   (cfg_ready_o)
);

// ===== sim/tb.sv =====
// Self-checking bench for the pulse derivative / smoothing filter core: directed and random
// pulses go in, and every output item is checked against a predictor kept in the bench.
// Depends on pdsf_pkg and pulse_derivative_smoothing_filter_core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Shrink the pulse length cap so that the saturating sample index is reachable
  localparam int unsigned PULSE_LEN_CAP = 100;
  localparam int unsigned SETTLE_CYCLES = 150;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned LONG_HOLD     = 500;
  localparam int unsigned RANDOM_ITEMS  = 345;
  localparam int unsigned PHASE_ITEMS   = 30;
  localparam int unsigned PRINT_LIMIT   = 40;

  // Indexes past the register file; writes to them must be dropped
  localparam logic [pdsf_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [pdsf_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam logic signed [15:0] S16_MAX = 16'sh7FFF;
  localparam logic signed [15:0] S16_MIN = 16'sh8000;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
  } sample_item_t;

  typedef struct packed {
    logic signed [15:0] value;
    logic               eop;
  } filt_out_t;

  typedef enum int {
    SHAPE_NOISE,
    SHAPE_RAIL,
    SHAPE_RAMP
  } shape_e;

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [15:0]                     s_axis_tdata  = '0;   // [15:0] sample
  logic                            s_axis_tlast  = 1'b0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [15:0]                     m_axis_tdata;         // [15:0] value
  logic                            m_axis_tlast;
  logic                            cfg_valid_i   = 1'b0;
  logic                            cfg_ready_o;
  logic [pdsf_pkg::CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [pdsf_pkg::CFG_DATA_W-1:0] cfg_data_i    = '0;

  sample_item_t feed_q[$];
  filt_out_t    expected_q[$];

  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned hold_req       = 0;
  int unsigned hold_ack       = 0;
  int unsigned hold_left      = 0;
  int unsigned cycle_cnt      = 0;
  int unsigned err_cnt        = 0;

  // Register file copy and the settings latched at the first sample of a pulse
  logic                           cfg_mode;
  logic [pdsf_pkg::D_W-1:0]       cfg_span;
  logic [pdsf_pkg::WIN_W-1:0]     cfg_win;
  logic signed [15:0]             cfg_gain;
  logic signed [15:0]             cfg_base;
  logic                           act_mode;
  int unsigned                    act_d;
  int unsigned                    act_w;
  logic signed [15:0]             act_gain;
  logic signed [15:0]             act_base;
  logic signed [15:0]             ring [pdsf_pkg::HIST_DEPTH];
  logic [pdsf_pkg::HIST_AW-1:0]   wr_ptr;
  int unsigned                    pulse_pos;

  pulse_derivative_smoothing_filter_core #(
    .MaxPulseLength(PULSE_LEN_CAP)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return S16_MAX;
    if (v < -32768) return S16_MIN;
    return 16'(v);
  endfunction

  // Age 0 is the newest stored sample
  function automatic logic signed [15:0] aged(int unsigned age);
    logic [pdsf_pkg::HIST_AW-1:0] slot;
    slot = wr_ptr - pdsf_pkg::HIST_AW'(1) - pdsf_pkg::HIST_AW'(age);
    return ring[slot];
  endfunction

  // Filtered value of the sample whose right edge is the newest stored one
  function automatic logic signed [15:0] filtered_value();
    longint      acc;
    longint      den;
    int unsigned half;
    if (!act_mode) begin
      den = 512 * longint'(act_d);
      acc = (longint'(aged(0)) - longint'(aged(2 * act_d))) * longint'(act_gain)
            + longint'(act_base) * den;
      return clip16(acc / den);
    end
    half = act_w / 2;
    acc  = 0;
    for (int unsigned k = 0; k < act_w; k++) acc += longint'(aged(2 * half - k));
    return clip16(acc / longint'(act_w));
  endfunction

  function automatic void latch_regs();
    act_mode = cfg_mode;
    act_d    = (cfg_span == '0) ? 1 : cfg_span;
    act_w    = (cfg_win == '0) ? 1 : cfg_win;
    if (act_d > pdsf_pkg::D_LIM) act_d = pdsf_pkg::D_LIM;
    if (act_w > pdsf_pkg::W_LIM) act_w = pdsf_pkg::W_LIM;
    act_gain = cfg_gain;
    act_base = cfg_base;
  endfunction

  function automatic void apply_reg(logic [pdsf_pkg::CFG_IDX_W-1:0] idx,
                                    logic [pdsf_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      pdsf_pkg::REG_MODE:      cfg_mode = data[0];
      pdsf_pkg::REG_HALF_SPAN: cfg_span = data[pdsf_pkg::D_W-1:0];
      pdsf_pkg::REG_WINDOW:    cfg_win  = data[pdsf_pkg::WIN_W-1:0];
      pdsf_pkg::REG_GAIN:      cfg_gain = data;
      pdsf_pkg::REG_BASELINE:  cfg_base = data;
      default: ;
    endcase
  endfunction

  function automatic void reset_predictor();
    cfg_mode  = 1'b0;
    cfg_span  = pdsf_pkg::D_W'(1);
    cfg_win   = pdsf_pkg::WIN_W'(1);
    cfg_gain  = pdsf_pkg::GAIN_RESET;
    cfg_base  = '0;
    for (int unsigned k = 0; k < pdsf_pkg::HIST_DEPTH; k++) ring[k] = '0;
    wr_ptr    = '0;
    pulse_pos = 0;
    latch_regs();
  endfunction

  // Store one sample and queue the output items it releases
  function automatic void take_sample(logic signed [15:0] x, logic last);
    int unsigned look;
    int unsigned pos;
    int unsigned first;
    filt_out_t   r;
    if (pulse_pos == 0) latch_regs();
    look = act_mode ? act_w / 2 : act_d;
    pos  = pulse_pos;
    ring[wr_ptr] = x;
    wr_ptr = wr_ptr + 1'b1;
    first  = 0;
    if (pos >= look) begin
      r.value = (pos - look >= look) ? filtered_value() : act_base;
      r.eop   = 1'b0;
      expected_q.insert(expected_q.size(), r);
      first = pos - look + 1;
    end
    if (last) begin
      // Release every pending output as baseline, flag the final one
      r.value = act_base;
      r.eop   = 1'b0;
      for (int unsigned k = first; k <= pos; k++) expected_q.insert(expected_q.size(), r);
      expected_q[expected_q.size() - 1].eop = 1'b1;
      pulse_pos = 0;
    end else if (pulse_pos < PULSE_LEN_CAP) begin
      pulse_pos++;
    end
  endfunction

  // ---------------------------------------------------------------- bench processes

  task automatic report_mismatch(string what);
    if (err_cnt < PRINT_LIMIT) $display("%0t mismatch: %s", $time, what);
    err_cnt++;
  endtask

  // Offer the next pending item, with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (feed_q.size() != 0 && $urandom_range(99, 0) >= src_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= feed_q[0].sample;
        s_axis_tlast  <= feed_q[0].last;
        void'(feed_q.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Count down a long output hold-off each time one is requested
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_ack  <= 0;
    end else if (hold_req != hold_ack) begin
      hold_left <= LONG_HOLD;
      hold_ack  <= hold_req;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Stall the output side at random and during a hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (hold_left == 0) && ($urandom_range(99, 0) >= sink_stall_pct);
    end
  end

  // Predict on accepted samples, check accepted output items
  always @(posedge clk_i) begin : mon
    filt_out_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) take_sample(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("value %h last %b with nothing expected",
                                    m_axis_tdata, m_axis_tlast));
        end else begin
          want = expected_q.pop_front();
          if (m_axis_tdata != want.value)
            report_mismatch($sformatf("value %h, want %h", m_axis_tdata, want.value));
          if (m_axis_tlast != want.eop)
            report_mismatch($sformatf("end_of_pulse %b, want %b", m_axis_tlast, want.eop));
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  // Hold valid across back-to-back writes; the caller drops it afterwards
  task automatic set_reg(logic [pdsf_pkg::CFG_IDX_W-1:0] idx,
                         logic [pdsf_pkg::CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    apply_reg(idx, data);
  endtask

  // Fill the bits above a narrow field with noise
  function automatic logic [pdsf_pkg::CFG_DATA_W-1:0] pad_field(
    logic [pdsf_pkg::CFG_DATA_W-1:0] field, int unsigned width);
    logic [pdsf_pkg::CFG_DATA_W-1:0] keep;
    keep = (pdsf_pkg::CFG_DATA_W'(1) << width) - 1'b1;
    return (pdsf_pkg::CFG_DATA_W'($urandom) & ~keep) | (field & keep);
  endfunction

  function automatic void feed(logic signed [15:0] x, logic last);
    sample_item_t it;
    it.sample = x;
    it.last   = last;
    feed_q.insert(feed_q.size(), it);
  endfunction

  function automatic void queue_pulse(int unsigned len, shape_e shape);
    logic signed [15:0] x;
    logic signed [15:0] lvl;
    lvl = 16'($urandom_range(4000, 0)) - 16'sd2000;
    for (int unsigned k = 0; k < len; k++) begin
      case (shape)
        SHAPE_RAIL: x = $urandom_range(1, 0) ? S16_MAX : S16_MIN;
        SHAPE_RAMP: begin
          lvl = lvl + 16'($urandom_range(600, 0)) - 16'sd300;
          x   = lvl;
        end
        default:    x = 16'($urandom);
      endcase
      feed(x, k == len - 1);
    end
  endfunction

  // Wait until everything fed has come back, then let the core go quiet
  task automatic drain();
    while (feed_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stim
    int unsigned                fed;
    int unsigned                phase;
    int unsigned                look;
    int unsigned                len;
    int unsigned                n;
    int unsigned                pick;
    logic                       mode;
    logic [pdsf_pkg::D_W-1:0]   span;
    logic [pdsf_pkg::WIN_W-1:0] win;
    logic signed [15:0]         gain;
    logic signed [15:0]         base;

    reset_predictor();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Writes to unused indexes leave the reset settings in place
    set_reg(REG_SPARE_LO, pdsf_pkg::CFG_DATA_W'($urandom));
    set_reg(REG_SPARE_HI, pdsf_pkg::CFG_DATA_W'($urandom));
    cfg_valid_i <= 1'b0;

    // Rail-to-rail derivative, then a one-sample and a too-short pulse
    feed(S16_MAX, 1'b0);
    feed(S16_MIN, 1'b0);
    feed(S16_MAX, 1'b0);
    feed(S16_MIN, 1'b0);
    feed('0, 1'b1);
    feed(16'sh1234, 1'b1);
    feed(S16_MIN, 1'b0);
    feed(S16_MAX, 1'b1);
    drain();

    // Extreme gain and baseline drive the result into both rails; span 0 acts as 1
    set_reg(pdsf_pkg::REG_GAIN, S16_MAX);
    set_reg(pdsf_pkg::REG_BASELINE, S16_MIN);
    set_reg(pdsf_pkg::REG_HALF_SPAN, pad_field('0, pdsf_pkg::D_W));
    cfg_valid_i <= 1'b0;
    feed(S16_MIN, 1'b0);
    feed(S16_MAX, 1'b0);
    feed(S16_MAX, 1'b0);
    feed(S16_MIN, 1'b1);
    drain();

    // Smoothing with window 0, which acts as 1
    set_reg(pdsf_pkg::REG_MODE, pad_field(16'd1, 1));
    set_reg(pdsf_pkg::REG_WINDOW, pad_field('0, pdsf_pkg::WIN_W));
    cfg_valid_i <= 1'b0;
    queue_pulse(3, SHAPE_NOISE);
    drain();

    // Even window, top baseline at the edges
    set_reg(pdsf_pkg::REG_WINDOW, pad_field(16'd2, pdsf_pkg::WIN_W));
    set_reg(pdsf_pkg::REG_BASELINE, S16_MAX);
    cfg_valid_i <= 1'b0;
    queue_pulse(4, SHAPE_NOISE);
    drain();

    // Widest span, then a mode change in mid-pulse that must wait for the next pulse
    set_reg(pdsf_pkg::REG_MODE, pad_field('0, 1));
    set_reg(pdsf_pkg::REG_HALF_SPAN, pad_field(16'd31, pdsf_pkg::D_W));
    set_reg(pdsf_pkg::REG_WINDOW, pad_field(16'd63, pdsf_pkg::WIN_W));
    set_reg(pdsf_pkg::REG_GAIN, S16_MIN);
    cfg_valid_i <= 1'b0;
    feed(S16_MAX, 1'b0);
    feed(S16_MIN, 1'b0);
    drain();
    set_reg(pdsf_pkg::REG_MODE, pad_field(16'd1, 1));
    cfg_valid_i <= 1'b0;
    feed(16'sh0F0F, 1'b1);
    queue_pulse(3, SHAPE_RAMP);
    drain();

    // Random phases: new settings and a new idling pattern each time
    fed   = 0;
    phase = 0;
    while (fed < RANDOM_ITEMS) begin
      mode = (phase % 4 == 0) ? 1'b0 : (phase % 4 == 1) ? 1'b1 : 1'($urandom_range(1, 0));
      span = (phase % 4 == 0) ? pdsf_pkg::D_W'(31) : pdsf_pkg::D_W'($urandom_range(8, 0));
      win  = (phase % 4 == 1) ? pdsf_pkg::WIN_W'(63)
                              : pdsf_pkg::WIN_W'($urandom_range(16, 0));
      case (phase % 3)
        0:       gain = $urandom_range(1, 0) ? S16_MAX : S16_MIN;
        1:       gain = 16'($urandom_range(1024, 0)) - 16'sd512;
        default: gain = 16'($urandom);
      endcase
      case (phase % 5)
        0:       base = $urandom_range(1, 0) ? S16_MAX : S16_MIN;
        1:       base = 16'($urandom);
        default: base = 16'($urandom_range(4000, 0)) - 16'sd2000;
      endcase
      set_reg(pdsf_pkg::REG_MODE, pad_field(16'(mode), 1));
      set_reg(pdsf_pkg::REG_HALF_SPAN, pad_field(16'(span), pdsf_pkg::D_W));
      set_reg(pdsf_pkg::REG_WINDOW, pad_field(16'(win), pdsf_pkg::WIN_W));
      set_reg(pdsf_pkg::REG_GAIN, gain);
      set_reg(pdsf_pkg::REG_BASELINE, base);
      if (phase % 3 == 2)
        set_reg(pdsf_pkg::CFG_IDX_W'($urandom_range(REG_SPARE_HI, REG_SPARE_LO)),
                pdsf_pkg::CFG_DATA_W'($urandom));
      cfg_valid_i <= 1'b0;

      case (phase % 4)
        0: begin
          src_idle_pct   <= 0;
          sink_stall_pct <= 0;
        end
        1: begin
          src_idle_pct   <= 45;
          sink_stall_pct <= 0;
        end
        2: begin
          src_idle_pct   <= 0;
          sink_stall_pct <= 45;
        end
        default: begin
          src_idle_pct   <= 21;
          sink_stall_pct <= 21;
        end
      endcase
      // Block the output long enough for the core to back up into its input
      if (phase == 2) hold_req <= hold_req + 1;

      look = mode ? ((win == '0) ? 1 : win) / 2 : ((span == '0) ? 1 : span);
      n = 0;
      while (n < PHASE_ITEMS) begin
        pick = $urandom_range(3, 0);
        if (phase == 5 && n == 0) len = $urandom_range(130, 105);
        else if (pick == 0) len = $urandom_range(3, 1);
        else if (pick == 1) len = $urandom_range(2 * look + 12, 1);
        else len = $urandom_range(2 * look + 12, 2 * look + 1);
        queue_pulse(len, shape_e'($urandom_range(2, 0)));
        n += len;
      end
      fed += n;
      phase++;
      drain();
    end

    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/pdsf_pkg.sv
rtl/core/pdsf_ram.sv
rtl/core/pdsf_div.sv
rtl/core/pdsf_datapath.sv
rtl/core/pdsf_ctrl.sv
rtl/core/pulse_derivative_smoothing_filter_core.sv
rtl/core/pdsf_checker.sv
sim/tb.sv
